// ----- rtl/core/rmts_pkg.sv -----
// Shared types and constants for the rate-monotonic task scheduler.
package rmts_pkg;

    localparam int MaxTasks = 16;
    localparam int SlotW    = $clog2(MaxTasks);
    localparam int CntW     = $clog2(MaxTasks + 1);
    localparam int IdW      = 22;
    localparam int PerW     = 16;
    localparam int ShareW   = 26;
    localparam int SumW     = 32;
    localparam int LimW     = 16;
    localparam logic [LimW-1:0] LimitReset = 16'd693;
    localparam logic [9:0] Thousand = 10'd1000;

    typedef enum logic [1:0] {
        MODE_REG   = 2'd0,
        MODE_YIELD = 2'd1,
        MODE_DEREG = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_NEW   = 2'd0,
        PH_SLEEP = 2'd1,
        PH_READY = 2'd2,
        PH_RUN   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADARG  = 3'd1,
        ST_ADMIT   = 3'd2,
        ST_DUP     = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_STATE   = 3'd5,
        ST_FULL    = 3'd6
    } t_status;

    // Controller -> datapath commands.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,     // capture the event, reset scan flags
        OP_DIV_START, // load the share divider
        OP_DIV_STEP,  // one quotient bit
        OP_SCAN,      // visit slot r_idx: lookup / free / tick / total
        OP_REGISTER,  // write new slot
        OP_YIELD,     // apply yield phase change
        OP_DEREG,     // free found slot
        OP_SCHED_PRE, // drop sleeping runner
        OP_PICK,      // visit slot r_idx: best ready
        OP_SCHED_FIN, // commit preemption
        OP_TOT_CLR    // clear the total accumulator
    } t_op;

    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_TICK,
        SCAN_TOTAL
    } t_scan;

    typedef struct packed {
        t_op        op;
        t_scan      scan;
        logic [SlotW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        t_mode  mode;
        logic   bad_arg;
        logic   admit_fail;
        logic   found;
        logic   has_free;
        t_phase found_phase;
        logic   woke;
    } t_stat;

endpackage

// ----- rtl/core/rmts_ctrl.sv -----
// Sequencer for event processing: scans, division, scheduling.
module rmts_ctrl
    import rmts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_res_load,
    input  logic  i_res_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LATCH, S_DIVLD, S_DIV, S_FIND, S_DECIDE,
        S_TICK, S_PRE, S_PICK, S_FIN, S_TCLR, S_TOT, S_DONE
    } t_state;

    t_state r_state;
    logic [SlotW-1:0] r_idx;
    logic [4:0] r_bit;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_load = (r_state == S_DONE) && i_res_free;

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.scan = SCAN_FIND;
        o_cmd.idx  = r_idx;
        unique case (r_state)
            // capture the event on the transfer edge
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LATCH : OP_NONE;
            S_LATCH: o_cmd.op = OP_NONE;
            S_DIVLD: o_cmd.op = OP_DIV_START;
            S_DIV:   o_cmd.op = OP_DIV_STEP;
            S_FIND:  o_cmd.op = OP_SCAN;
            S_TICK: begin
                o_cmd.op   = OP_SCAN;
                o_cmd.scan = SCAN_TICK;
            end
            S_TOT: begin
                o_cmd.op   = OP_SCAN;
                o_cmd.scan = SCAN_TOTAL;
            end
            S_DECIDE: begin
                unique case (i_stat.mode)
                    MODE_REG:   o_cmd.op = OP_REGISTER;
                    MODE_YIELD: o_cmd.op = OP_YIELD;
                    MODE_DEREG: o_cmd.op = OP_DEREG;
                    default:    o_cmd.op = OP_NONE;
                endcase
            end
            S_PRE:  o_cmd.op = OP_SCHED_PRE;
            S_PICK: o_cmd.op = OP_PICK;
            S_FIN:  o_cmd.op = OP_SCHED_FIN;
            S_TCLR: o_cmd.op = OP_TOT_CLR;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    localparam logic [SlotW-1:0] LastIdx = SlotW'(MaxTasks - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_LATCH;
                S_LATCH: begin
                    r_idx <= '0;
                    if (i_stat.mode == MODE_TICK) begin
                        r_state <= S_TICK;
                    end else if (i_stat.mode == MODE_REG) begin
                        r_state <= S_DIVLD;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                S_DIVLD: begin
                    r_bit   <= 5'd25;
                    r_state <= i_stat.bad_arg ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) r_state <= S_FIND;
                end
                S_FIND: begin
                    r_idx <= r_idx + SlotW'(1);
                    if (r_idx == LastIdx) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    unique case (i_stat.mode)
                        MODE_REG: begin
                            if (!i_stat.admit_fail && !i_stat.found
                                && i_stat.has_free) begin
                                r_state <= S_TCLR;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        MODE_YIELD: begin
                            if (i_stat.found && (i_stat.found_phase == PH_NEW
                                || i_stat.found_phase == PH_RUN)) begin
                                r_state <= S_PRE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        MODE_DEREG: r_state <= i_stat.found ? S_TCLR : S_DONE;
                        default:    r_state <= S_DONE;
                    endcase
                end
                S_TICK: begin
                    r_idx <= r_idx + SlotW'(1);
                    if (r_idx == LastIdx) r_state <= S_PRE;
                end
                S_PRE: begin
                    if (i_stat.mode == MODE_TICK && !i_stat.woke) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_idx <= r_idx + SlotW'(1);
                    if (r_idx == LastIdx) r_state <= S_FIN;
                end
                S_FIN:  r_state <= S_DONE;
                S_TCLR: begin
                    r_idx   <= '0;
                    r_state <= S_TOT;
                end
                S_TOT: begin
                    r_idx <= r_idx + SlotW'(1);
                    if (r_idx == LastIdx) r_state <= S_DONE;
                end
                S_DONE: if (i_res_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/rmts_dp.sv -----
// Task table, share divider, scan and pick datapath.
module rmts_dp
    import rmts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_mode,
    input  logic [IdW-1:0]   i_task_id,
    input  logic [PerW-1:0]  i_period_ms,
    input  logic [PerW-1:0]  i_runtime_ms,
    input  logic [LimW-1:0]  i_limit,
    output t_stat            o_stat,
    output logic [2:0]       o_status,
    output logic             o_running_valid,
    output logic [IdW-1:0]   o_running_task_id,
    output logic [SumW-1:0]  o_utilization_sum
);

    logic [MaxTasks-1:0]  r_used;
    logic [MaxTasks-1:0]  r_armed;
    logic [IdW-1:0]       r_tid   [MaxTasks];
    logic [PerW-1:0]      r_per   [MaxTasks];
    logic [ShareW-1:0]    r_share [MaxTasks];
    t_phase               r_phase [MaxTasks];
    logic [PerW-1:0]      r_cnt   [MaxTasks];

    t_mode               r_mode;
    logic [IdW-1:0]      r_id;
    logic [PerW-1:0]     r_per_in;
    logic [ShareW-1:0]   r_num;   // dividend shifting out, quotient in
    logic [PerW:0]       r_rem;
    logic                r_run_p;
    logic [SlotW-1:0]    r_run_s;
    logic [SumW-1:0]     r_total;
    logic [2:0]          r_status;
    logic                r_found;
    logic [SlotW-1:0]    r_fslot;
    logic                r_free;
    logic [SlotW-1:0]    r_fidx;
    logic                r_woke;
    logic                r_best_v;
    logic [SlotW-1:0]    r_best;
    logic [PerW-1:0]     r_best_p;

    logic [SlotW-1:0] w_i;
    logic [PerW:0]    w_rem_sh;
    logic             w_ge;
    logic [SumW:0]    w_add;
    logic [SumW-1:0]  w_sat;
    logic             w_bad;

    // saturating accumulate of one slot's share into the running total
    function automatic logic [SumW-1:0] sat_acc(input logic [SumW-1:0] a,
                                                input logic [ShareW-1:0] b);
        logic [SumW:0] s;
        s = {1'b0, a} + {{(SumW+1-ShareW){1'b0}}, b};
        return s[SumW] ? '1 : s[SumW-1:0];
    endfunction

    assign w_i      = i_cmd.idx;
    assign w_rem_sh = {r_rem[PerW-1:0], r_num[ShareW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_per_in};
    assign w_bad    = (r_per_in == '0) || (r_num == '0);
    // total + share, saturated; share is r_num once division is done
    assign w_add    = {1'b0, r_total} + {{(SumW+1-ShareW){1'b0}}, r_num};
    assign w_sat    = w_add[SumW] ? '1 : w_add[SumW-1:0];

    assign o_stat.mode        = r_mode;
    assign o_stat.bad_arg     = w_bad;
    assign o_stat.admit_fail  = w_sat > {{(SumW-LimW){1'b0}}, i_limit};
    assign o_stat.found       = r_found;
    assign o_stat.has_free    = r_free;
    assign o_stat.found_phase = r_phase[r_fslot];
    assign o_stat.woke        = r_woke;

    assign o_status          = r_status;
    assign o_running_valid   = r_run_p;
    assign o_running_task_id = r_run_p ? r_tid[r_run_s] : '0;
    assign o_utilization_sum = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_armed  <= '0;
            r_run_p  <= 1'b0;
            r_run_s  <= '0;
            r_total  <= '0;
            r_status <= ST_OK;
            r_mode   <= MODE_REG;
            for (int k = 0; k < MaxTasks; k++) r_cnt[k] <= '0;
        end else begin
            case (i_cmd.op)
                OP_LATCH: begin
                    r_mode   <= t_mode'(i_mode);
                    r_id     <= i_task_id;
                    r_per_in <= i_period_ms;
                    r_num    <= ShareW'(i_runtime_ms);
                    r_status <= ST_OK;
                    r_found  <= 1'b0;
                    r_fslot  <= '0;
                    r_free   <= 1'b0;
                    r_fidx   <= '0;
                    r_woke   <= 1'b0;
                    r_best_v <= 1'b0;
                    r_best   <= '0;
                    r_best_p <= '0;
                end
                OP_DIV_START: begin
                    // dividend = 1000 * runtime, fits in 26 bits
                    r_num <= ShareW'(r_num[PerW-1:0]) * ShareW'(Thousand);
                    r_rem <= '0;
                    if (w_bad) r_status <= ST_BADARG;
                end
                OP_DIV_STEP: begin
                    r_rem <= w_ge ? (w_rem_sh - {1'b0, r_per_in}) : w_rem_sh;
                    r_num <= {r_num[ShareW-2:0], w_ge};
                end
                OP_SCAN: begin
                    case (i_cmd.scan)
                        SCAN_FIND: begin
                            if (r_used[w_i] && r_tid[w_i] == r_id && !r_found) begin
                                r_found <= 1'b1;
                                r_fslot <= w_i;
                            end
                            if (!r_used[w_i] && !r_free) begin
                                r_free <= 1'b1;
                                r_fidx <= w_i;
                            end
                        end
                        SCAN_TICK: begin
                            if (r_used[w_i] && r_armed[w_i]) begin
                                if (r_cnt[w_i] > PerW'(1)) begin
                                    r_cnt[w_i] <= r_cnt[w_i] - PerW'(1);
                                end else begin
                                    r_cnt[w_i] <= r_per[w_i];
                                    if (r_phase[w_i] == PH_SLEEP) begin
                                        r_phase[w_i] <= PH_READY;
                                        r_woke       <= 1'b1;
                                    end else begin
                                        r_status <= ST_STATE;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (r_used[w_i]) begin
                                r_total <= sat_acc(r_total, r_share[w_i]);
                            end
                        end
                    endcase
                end
                OP_REGISTER: begin
                    if (o_stat.admit_fail) begin
                        r_status <= ST_ADMIT;
                    end else if (r_found) begin
                        r_status <= ST_DUP;
                    end else if (!r_free) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_used[r_fidx]  <= 1'b1;
                        r_tid[r_fidx]   <= r_id;
                        r_per[r_fidx]   <= r_per_in;
                        r_share[r_fidx] <= r_num;
                        r_phase[r_fidx] <= PH_NEW;
                        r_cnt[r_fidx]   <= '0;
                        r_armed[r_fidx] <= 1'b0;
                    end
                end
                OP_YIELD: begin
                    if (!r_found) begin
                        r_status <= ST_UNKNOWN;
                    end else if (r_phase[r_fslot] == PH_NEW) begin
                        r_phase[r_fslot] <= PH_READY;
                        r_cnt[r_fslot]   <= r_per[r_fslot];
                        r_armed[r_fslot] <= 1'b1;
                    end else if (r_phase[r_fslot] == PH_RUN) begin
                        r_phase[r_fslot] <= PH_SLEEP;
                    end else begin
                        r_status <= ST_STATE;
                    end
                end
                OP_DEREG: begin
                    if (r_found) begin
                        r_used[r_fslot]  <= 1'b0;
                        r_armed[r_fslot] <= 1'b0;
                        r_cnt[r_fslot]   <= '0;
                        if (r_run_p && r_run_s == r_fslot) r_run_p <= 1'b0;
                    end
                end
                OP_SCHED_PRE: begin
                    if (r_run_p && r_phase[r_run_s] == PH_SLEEP) r_run_p <= 1'b0;
                end
                OP_PICK: begin
                    if (r_used[w_i] && r_phase[w_i] == PH_READY
                        && (!r_best_v || r_per[w_i] < r_best_p)) begin
                        r_best_v <= 1'b1;
                        r_best   <= w_i;
                        r_best_p <= r_per[w_i];
                    end
                end
                OP_SCHED_FIN: begin
                    if (r_best_v && !(r_run_p && r_per[r_run_s] <= r_best_p)) begin
                        if (r_run_p) r_phase[r_run_s] <= PH_READY;
                        r_phase[r_best] <= PH_RUN;
                        r_run_s <= r_best;
                        r_run_p <= 1'b1;
                    end
                end
                OP_TOT_CLR: r_total <= '0;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/rate_monotonic_task_scheduler_unit.sv -----
// Top level of the rate-monotonic task scheduler.
// One event is taken at a time. From input transfer to result load: register
// runs a 26-step share division, a 16-slot lookup and, once admitted, a 16-slot
// share total, skipping all three when period or runtime is zero; yield runs
// the lookup, plus a 16-slot ready-task pick if a phase changes; tick
// scans all slots, plus the pick if a task wakes; deregister runs the lookup
// plus the total for a known id. Each slot scan visits one table entry per cycle.
// The result sits in an output register so the next event can be taken
// while it waits; a result still held there stalls the next one's load.
// The admission limit may be written only while idle.
module rate_monotonic_task_scheduler_unit
    import rmts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LimW-1:0]  i_admission_limit,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [IdW-1:0]   i_task_id,
    input  logic [PerW-1:0]  i_period_ms,
    input  logic [PerW-1:0]  i_runtime_ms,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_status,
    output logic             o_running_valid,
    output logic [IdW-1:0]   o_running_task_id,
    output logic [SumW-1:0]  o_utilization_sum
);

    logic [LimW-1:0] r_limit;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_load;
    logic  w_free;
    logic [2:0]      w_status;
    logic            w_rv;
    logic [IdW-1:0]  w_rid;
    logic [SumW-1:0] w_sum;

    assign o_cfg_ready = 1'b1;
    assign w_free      = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LimitReset;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_limit <= i_admission_limit;
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status          <= w_status;
            o_running_valid   <= w_rv;
            o_running_task_id <= w_rid;
            o_utilization_sum <= w_sum;
        end
    end

    rmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_res_load (w_load),
        .i_res_free (w_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rmts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mode            (i_mode),
        .i_task_id         (i_task_id),
        .i_period_ms       (i_period_ms),
        .i_runtime_ms      (i_runtime_ms),
        .i_limit           (r_limit),
        .o_stat            (w_stat),
        .o_status          (w_status),
        .o_running_valid   (w_rv),
        .o_running_task_id (w_rid),
        .o_utilization_sum (w_sum)
    );

endmodule

// ----- rtl/core/rmts_chk.sv -----
// Port-level checker for the scheduler, bound to the top level.
module rmts_chk
    import rmts_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [2:0]      o_status,
    input logic            o_running_valid,
    input logic [IdW-1:0]  o_running_task_id
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'd6)
        else $error("status code out of range");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_running_valid |-> o_running_task_id == '0)
        else $error("running id without running task");

    a_no_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while busy");

endmodule

bind rate_monotonic_task_scheduler_unit rmts_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_running_valid   (o_running_valid),
    .o_running_task_id (o_running_task_id)
);
